[hw/rtl/sil_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted index insert/lookup engine.
// No dependencies; every other file of the block imports this package.
package sil_pkg;

    localparam int KEY_FIELD_W = 64;
    localparam int OFFSET_W    = 24;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One finished request, handed from the sequencer to the output register.
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [OFFSET_W-1:0] offset;
    } sil_result_t;

endpackage

[hw/rtl/sorted_index_insert_lookup.sv]
`timescale 1ns / 1ps
// Top level of the sorted index engine: request/result ports and output register.
// Depends on sil_pkg, sil_ctrl and sil_table_mem.
//
// The block keeps a table of (key, record offset) pairs sorted by unsigned key.
// Each request on the s_ channel is an insert (s_tuser = 0) or a lookup
// (s_tuser = 1); each request yields exactly one result on the m_ channel.
// An insert walks down from the end of the table, moving one larger entry up
// per cycle while the output register is free, then writes the new pair after
// all equal keys. A full table answers with status full.
// A lookup is a binary search that probes one entry per cycle while the
// output register is free. Both are bounded by the single memory read port,
// whose registered data feeds the compare of each step.
// Requests are taken one at a time: s_tready is high only while the engine is
// idle, and it rises again the cycle after a result is loaded into the output
// register, even if that result is still waiting on m_tready.
// If the receiver stalls while a second request finishes, the engine holds its
// step until the output register frees up; nothing is dropped.
// Reset empties the table at once (the entry count clears); no clearing pass
// runs, since entries at or above the count are never read.
module sorted_index_insert_lookup #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // [63:0] key, [87:64] record_offset
    input  logic [0:0]  s_tuser,   // [0] operation (0 insert, 1 lookup)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] found_offset
    output logic [1:0]  m_tuser    // [1:0] status
);
    import sil_pkg::*;

    localparam int KW = 8 * KEY_BYTES;
    localparam int IW = $clog2(TABLE_DEPTH);

    sil_result_t         result;
    logic                out_free;

    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [OFFSET_W-1:0] m_offset_reg, m_offset_next;

    logic                mem_rd_en, mem_wr_en;
    logic [IW-1:0]       mem_rd_addr, mem_wr_addr;
    logic [KW-1:0]       mem_rd_key, mem_wr_key;
    logic [OFFSET_W-1:0] mem_rd_offset, mem_wr_offset;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    sil_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req_lookup    (s_tuser[0]),
        .req_key       (s_tdata[63:0]),
        .req_offset    (s_tdata[87:64]),
        .out_free      (out_free),
        .result        (result),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_key    (mem_rd_key),
        .mem_rd_offset (mem_rd_offset),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_key    (mem_wr_key),
        .mem_wr_offset (mem_wr_offset)
    );

    sil_table_mem #(
        .ADDR_W (IW),
        .KEY_W  (KW)
    ) u_mem (
        .aclk      (aclk),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .rd_key    (mem_rd_key),
        .rd_offset (mem_rd_offset),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_key    (mem_wr_key),
        .wr_offset (mem_wr_offset)
    );

    // Output register: loaded by a finished request, cleared once taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_offset_next = m_offset_reg;
        if (result.valid) begin
            m_valid_next  = 1'b1;
            m_status_next = result.status;
            m_offset_next = result.offset;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_offset_reg;
    assign m_tuser  = m_status_reg;

    // A finished request never overwrites a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> out_free)
        else $error("result produced while output register is occupied");

    // A new request cannot be taken in the same cycle that one finishes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !result.valid)
        else $error("request accepted while a result was being produced");

    // After a request is taken the engine is not ready in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("engine ready again right after accepting a request");

    // Only a successful lookup carries a nonzero offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_DONE)) |-> (m_tdata == '0))
        else $error("nonzero offset on a not-found or full result");

endmodule

[hw/rtl/sil_table_mem.sv]
`timescale 1ns / 1ps
// Entry table: one synchronous memory of (key, offset) pairs.
// One write port and one registered read port; uses sil_pkg for the offset width.
module sil_table_mem #(
    parameter int ADDR_W = 8,
    parameter int KEY_W  = 64
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [KEY_W-1:0]             rd_key,
    output logic [sil_pkg::OFFSET_W-1:0] rd_offset,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [KEY_W-1:0]             wr_key,
    input  logic [sil_pkg::OFFSET_W-1:0] wr_offset
);
    import sil_pkg::*;

    localparam int ENTRY_W = KEY_W + OFFSET_W;
    localparam int DEPTH   = 1 << ADDR_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_offset};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key    = rd_data_reg[ENTRY_W-1:OFFSET_W];
    assign rd_offset = rd_data_reg[OFFSET_W-1:0];

endmodule

[hw/rtl/sil_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer: insertion shift loop and binary search over the table memory.
// Depends on sil_pkg and drives the ports of sil_table_mem.
module sil_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_lookup,
    input  logic [sil_pkg::KEY_FIELD_W-1:0] req_key,
    input  logic [sil_pkg::OFFSET_W-1:0]    req_offset,
    input  logic                            out_free,
    output sil_pkg::sil_result_t            result,
    output logic                            mem_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  mem_rd_addr,
    input  logic [8*KEY_BYTES-1:0]          mem_rd_key,
    input  logic [sil_pkg::OFFSET_W-1:0]    mem_rd_offset,
    output logic                            mem_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  mem_wr_addr,
    output logic [8*KEY_BYTES-1:0]          mem_wr_key,
    output logic [sil_pkg::OFFSET_W-1:0]    mem_wr_offset
);
    import sil_pkg::*;

    localparam int KW = 8 * KEY_BYTES;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_LK   = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [OFFSET_W-1:0]  off_reg, off_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        low_reg, low_next;
    logic [CW-1:0]        high_reg, high_next;
    logic [CW-1:0]        mid_reg, mid_next;
    status_t              fin_status_reg, fin_status_next;

    logic [KW-1:0]        key_in;
    logic [CW-1:0]        cnt_m1, pos_m1, pos_m2, mid_p1;
    logic [CW:0]          sum_left, sum_right;

    assign key_in    = req_key[KEY_FIELD_W-1 -: KW];
    assign cnt_m1    = count_reg - CW'(1);
    assign pos_m1    = pos_reg - CW'(1);
    assign pos_m2    = pos_reg - CW'(2);
    assign mid_p1    = mid_reg + CW'(1);
    // Candidate midpoints for both outcomes, formed in parallel with the key compare.
    assign sum_left  = {1'b0, low_reg} + {1'b0, mid_reg} - (CW+1)'(1);
    assign sum_right = {1'b0, mid_reg} + {1'b0, high_reg};

    assign req_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        off_next        = off_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        mid_next        = mid_reg;
        fin_status_next = fin_status_reg;
        result          = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pos_reg[IW-1:0];
        mem_wr_key      = key_reg;
        mem_wr_offset   = off_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    key_next = key_in;
                    off_next = req_offset;
                    if (!req_lookup) begin
                        if (count_reg == CW'(TABLE_DEPTH)) begin
                            fin_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end else begin
                            pos_next   = count_reg;
                            state_next = S_INS;
                            if (count_reg != '0) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = cnt_m1[IW-1:0];
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            fin_status_next = ST_NOT_FOUND;
                            state_next      = S_FIN;
                        end else begin
                            low_next    = '0;
                            high_next   = count_reg;
                            mid_next    = {1'b0, cnt_m1[CW-1:1]};
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = IW'(cnt_m1 >> 1);
                            state_next  = S_LK;
                        end
                    end
                end
            end
            S_INS: begin
                if (out_free) begin
                    priority if (pos_reg == '0 || !(mem_rd_key > key_reg)) begin
                        // Slot found: the new pair lands after all equal keys.
                        mem_wr_en     = 1'b1;
                        count_next    = count_reg + CW'(1);
                        result.valid  = 1'b1;
                        result.status = ST_DONE;
                        state_next    = S_IDLE;
                    end else begin
                        mem_wr_en     = 1'b1;
                        mem_wr_key    = mem_rd_key;
                        mem_wr_offset = mem_rd_offset;
                        pos_next      = pos_m1;
                        if (pos_m1 != '0) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = pos_m2[IW-1:0];
                        end
                    end
                end
            end
            S_LK: begin
                if (out_free) begin
                    priority if (mem_rd_key == key_reg) begin
                        result.valid  = 1'b1;
                        result.status = ST_DONE;
                        result.offset = mem_rd_offset;
                        state_next    = S_IDLE;
                    end else if (key_reg < mem_rd_key) begin
                        if (low_reg < mid_reg) begin
                            high_next   = mid_reg;
                            mid_next    = sum_left[CW:1];
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = sum_left[IW:1];
                        end else begin
                            result.valid  = 1'b1;
                            result.status = ST_NOT_FOUND;
                            state_next    = S_IDLE;
                        end
                    end else begin
                        if (mid_p1 < high_reg) begin
                            low_next    = mid_p1;
                            mid_next    = sum_right[CW:1];
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = sum_right[IW:1];
                        end else begin
                            result.valid  = 1'b1;
                            result.status = ST_NOT_FOUND;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    result.valid  = 1'b1;
                    result.status = fin_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        off_reg        <= off_next;
        pos_reg        <= pos_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        mid_reg        <= mid_next;
        fin_status_reg <= fin_status_next;
    end

endmodule
